@@ sv/llss_pkg.sv @@
`default_nettype none

package llss_pkg;

    // table geometry
    localparam int MAX_SERVERS = 16;
    localparam int IDX_W       = $clog2(MAX_SERVERS);
    localparam int ACT_W       = 5;
    localparam int LOAD_W      = 32;
    localparam int FAIL_W      = 32;
    localparam int REQ_CNT_W   = 16;
    localparam int CFG_DATA_W  = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register reset values
    localparam logic [ACT_W-1:0]     ACTIVE_RESET = ACT_W'(MAX_SERVERS);
    localparam logic [REQ_CNT_W-1:0] RPC_RESET    = REQ_CNT_W'(5);

    // configuration register indexes
    localparam logic REG_ACTIVE_SERVERS     = 1'b0;
    localparam logic REG_REQUESTS_PER_CHECK = 1'b1;

    // opcodes
    localparam logic [1:0] OP_DISPATCH  = 2'd0;
    localparam logic [1:0] OP_REPORT    = 2'd1;
    localparam logic [1:0] OP_MARK_DOWN = 2'd2;
    localparam logic [1:0] OP_END_ROUND = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        server_index;
        logic              report_ok;
        logic [LOAD_W-1:0] reported_load;
        logic [FAIL_W-1:0] reported_failures;
    } req_t;

    typedef struct packed {
        logic [3:0] chosen_index;
        logic       chosen_valid;
        logic       check_due;
    } rsp_t;

    // classified request as it sits in the queue
    typedef struct packed {
        req_t req;
        logic is_dispatch;
        logic idx_ok;
    } cmd_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [ACT_W-1:0]     active_servers;
        logic [REQ_CNT_W-1:0] requests_per_check;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/llss_front.sv @@
`default_nettype none

module llss_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_ready,
    input  llss_pkg::req_t    req_data,
    output logic              cmd_valid,
    output llss_pkg::cmd_t    cmd_data,
    input  wire               cmd_pop
);
    import llss_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    cmd_t              cmd_in;

    // classify the incoming request
    always_comb
    begin
        cmd_in.req         = req_data;
        cmd_in.is_dispatch = (req_data.opcode == OP_DISPATCH);
        cmd_in.idx_ok      = ({1'b0, req_data.server_index} < 5'(MAX_SERVERS));
    end

    assign req_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req_valid && req_ready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_data  = queue_mem[rd_ptr_reg];

    // advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ sv/llss_back.sv @@
`default_nettype none

module llss_back (
    input  wire               clk,
    input  wire               rst_n,
    input  llss_pkg::cfg_t    cfg,
    input  wire               cmd_valid,
    input  llss_pkg::cmd_t    cmd_data,
    output logic              cmd_pop,
    output logic              rsp_valid,
    input  wire               rsp_ready,
    output llss_pkg::rsp_t    rsp_data
);
    import llss_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Load and failure entries need no reset: an entry only comes up through
    // a good report, which writes both counts.
    logic [LOAD_W-1:0]      load_mem [MAX_SERVERS];
    logic [FAIL_W-1:0]      fail_mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] down_reg, down_next;

    logic [1:0]             state_reg, state_next;
    cmd_t                   cmd_reg;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [LOAD_W-1:0]      best_load_reg, best_load_next;
    logic [FAIL_W-1:0]      best_fail_reg, best_fail_next;
    logic [REQ_CNT_W-1:0]   reqs_reg, reqs_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [ACT_W-1:0]       used_n;
    logic [IDX_W-1:0]       last_idx;
    logic [LOAD_W-1:0]      cur_load;
    logic [FAIL_W-1:0]      cur_fail;
    logic                   better;
    logic                   finish_fire;
    logic                   load_we, fail_we;
    logic [IDX_W-1:0]       wr_idx;
    logic [LOAD_W-1:0]      load_wdata;
    logic [IDX_W-1:0]       tgt_idx;

    // clamp the active count into the table
    always_comb
    begin
        used_n = cfg.active_servers;
        if (used_n == '0)
        begin
            used_n = ACT_W'(1);
        end
        if (used_n > ACT_W'(MAX_SERVERS))
        begin
            used_n = ACT_W'(MAX_SERVERS);
        end
        last_idx = IDX_W'(used_n - 1'b1);
    end

    assign tgt_idx  = IDX_W'(cmd_reg.req.server_index);
    assign cur_load = load_mem[scan_idx_reg];
    assign cur_fail = fail_mem[scan_idx_reg];

    // compare the scanned entry against the best so far
    always_comb
    begin
        better = !down_reg[scan_idx_reg] &&
                 (!found_reg || (cur_load < best_load_reg) ||
                  ((cur_load == best_load_reg) && (cur_fail < best_fail_reg)));
    end

    assign cmd_pop     = (state_reg == ST_IDLE) && cmd_valid;
    assign finish_fire = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_load_next = best_load_reg;
        best_fail_next = best_fail_reg;
        down_next      = down_reg;
        reqs_next      = reqs_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        load_we        = 1'b0;
        fail_we        = 1'b0;
        wr_idx         = tgt_idx;
        load_wdata     = cmd_reg.req.reported_load;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    best_idx_next = '0;
                    state_next    = cmd_data.is_dispatch ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (better)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_idx_reg;
                    best_load_next = cur_load;
                    best_fail_next = cur_fail;
                end
                if (scan_idx_reg == last_idx)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    rsp_next.chosen_index = '0;
                    rsp_next.chosen_valid = 1'b0;
                    case (cmd_reg.req.opcode)
                        OP_DISPATCH:
                        begin
                            if (found_reg)
                            begin
                                load_we    = 1'b1;
                                wr_idx     = best_idx_reg;
                                load_wdata = (best_load_reg == '1) ? best_load_reg
                                                                   : best_load_reg + 1'b1;
                                rsp_next.chosen_index = 4'(best_idx_reg);
                                rsp_next.chosen_valid = 1'b1;
                            end
                            if (reqs_reg != '1)
                            begin
                                reqs_next = reqs_reg + 1'b1;
                            end
                        end
                        OP_REPORT:
                        begin
                            if (cmd_reg.idx_ok)
                            begin
                                if (cmd_reg.req.report_ok)
                                begin
                                    load_we            = 1'b1;
                                    fail_we            = 1'b1;
                                    down_next[tgt_idx] = 1'b0;
                                end
                                else
                                begin
                                    down_next[tgt_idx] = 1'b1;
                                end
                            end
                        end
                        OP_MARK_DOWN:
                        begin
                            if (cmd_reg.idx_ok)
                            begin
                                down_next[tgt_idx] = 1'b1;
                            end
                        end
                        default:
                        begin
                            reqs_next = '0;
                        end
                    endcase
                    rsp_next.check_due = (reqs_next >= cfg.requests_per_check);
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            down_reg      <= '1;
            reqs_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            down_reg      <= down_next;
            reqs_reg      <= reqs_next;
            rsp_valid_reg <= rsp_valid_next;
            found_reg     <= found_next;
        end
    end

    // latch the popped request and the scan datapath
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end
        scan_idx_reg  <= scan_idx_next;
        best_idx_reg  <= best_idx_next;
        best_load_reg <= best_load_next;
        best_fail_reg <= best_fail_next;
        rsp_reg       <= rsp_next;
    end

    // write the server table
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            load_mem[wr_idx] <= load_wdata;
        end
        if (fail_we)
        begin
            fail_mem[wr_idx] <= cmd_reg.req.reported_failures;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

@@ sv/least_loaded_server_select_top.sv @@
// Flow: an accepted request waits in the queue until the idle back end pops it; a
// dispatch then scans the active entries in the scan state, one table entry per cycle,
// while report, mark-down and end-of-round requests go straight to the finish state,
// which waits until the result register is empty or being read, then writes the result.
// Reset: all servers down, request counter zero, active_servers 16, requests_per_check 5.
`default_nettype none

module least_loaded_server_select_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire                                 cfg_index,
    input  wire [llss_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                 req_valid,
    output logic                                req_ready,
    input  llss_pkg::req_t                      req_data,
    output logic                                rsp_valid,
    input  wire                                 rsp_ready,
    output llss_pkg::rsp_t                      rsp_data
);
    import llss_pkg::*;

    logic [ACT_W-1:0]     active_reg;
    logic [REQ_CNT_W-1:0] rpc_reg;
    cfg_t                 cfg;
    logic                 cmd_valid;
    logic                 cmd_pop;
    cmd_t                 cmd_data;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            rpc_reg    <= RPC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVE_SERVERS:     active_reg <= cfg_data[ACT_W-1:0];
                REG_REQUESTS_PER_CHECK: rpc_reg    <= cfg_data[REQ_CNT_W-1:0];
                default:                active_reg <= active_reg;
            endcase
        end
    end

    assign cfg.active_servers     = active_reg;
    assign cfg.requests_per_check = rpc_reg;

    llss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_pop   (cmd_pop)
    );

    llss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire
